@@ rtl/soh_etb_packet_deframer_unit_defines.svh @@
// ----------------------------------------------------------------------------
// SOH/ETB deframer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SOH_ETB_PACKET_DEFRAMER_UNIT_DEFINES_SVH
`define SOH_ETB_PACKET_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SOHDF_CHK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SOHDF_CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sohdf_pkg.sv @@
// ----------------------------------------------------------------------------
// SOH/ETB deframer package
// Types and fixed constants shared by the front end, queue and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sohdf_pkg;

  // Field widths of a queue entry; they cover the whole supported word range.
  localparam int ROW_FIELD_W = 6;
  localparam int CNT_FIELD_W = 6;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CODE   = 2'd1;

  // Operation carried from front end to back end.
  typedef enum logic [1:0] {
    OP_STORE,
    OP_BAD,
    OP_HEADER,
    OP_WORDS
  } op_t;

  // One queue entry. For OP_STORE, data is the payload byte at row/lane;
  // for the frame operations, data is the packet id and cnt the word count.
  typedef struct packed {
    op_t                    op;
    logic [7:0]             data;
    logic [ROW_FIELD_W-1:0] row;
    logic [1:0]             lane;
    logic [CNT_FIELD_W-1:0] cnt;
  } entry_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_SEND
  } bstate_t;

endpackage

@@ rtl/sohdf_queue.sv @@
// ----------------------------------------------------------------------------
// SOH/ETB deframer operation queue
// Two-entry FIFO that decouples the byte classifier from the result sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sohdf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sohdf_pkg::entry_t push_entry,
  input  logic              pop,
  output sohdf_pkg::entry_t head,
  output sohdf_pkg::qstat_t stat
);

  logic [1:0]        count_r;
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  sohdf_pkg::entry_t ent_r [2];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head       = ent_r[rd_ptr_r];
  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);

endmodule

@@ rtl/sohdf_front.sv @@
// ----------------------------------------------------------------------------
// SOH/ETB deframer front end
// Classifies received bytes, tracks the frame fill and queues store and
// frame-check operations; also holds the configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sohdf_front #(
  parameter int MAX_WORDS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_rx_byte,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sohdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data,
  input  sohdf_pkg::qstat_t               q_stat,
  output logic                            push,
  output sohdf_pkg::entry_t               push_entry
);

  localparam int STORE_DEPTH = 2 + 4 * MAX_WORDS;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  logic [7:0]       start_code_r;
  logic [7:0]       end_code_r;
  logic             collecting_r, collecting_nxt;
  logic [CNT_W-1:0] stored_count_r, stored_count_nxt;
  logic             overflowed_r, overflowed_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [7:0]       cnt_r, cnt_nxt;

  logic             accept;
  logic [CNT_W-1:0] pay_off;
  logic             too_short;
  logic             too_big;
  logic             len_ok;
  logic             frame_bad;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_stat.full;
  assign accept    = in_valid && !q_stat.full;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r <= 8'd1;
      end_code_r   <= 8'd23;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sohdf_pkg::CFG_START_CODE: start_code_r <= cfg_data;
        sohdf_pkg::CFG_END_CODE:   end_code_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame check on the bytes gathered so far.
  assign pay_off   = stored_count_r - CNT_W'(2);
  assign too_short = (stored_count_r < CNT_W'(2));
  assign too_big   = ({1'b0, cnt_r} > 9'(MAX_WORDS));
  assign len_ok    = ((10'(stored_count_r) - 10'd2) == {cnt_r, 2'b00});
  assign frame_bad = overflowed_r || too_short || too_big || !len_ok;

  // Byte classification.
  always_comb begin
    collecting_nxt   = collecting_r;
    stored_count_nxt = stored_count_r;
    overflowed_nxt   = overflowed_r;
    id_nxt           = id_r;
    cnt_nxt          = cnt_r;
    push             = 1'b0;
    push_entry       = '0;
    push_entry.op    = sohdf_pkg::OP_STORE;
    if (accept) begin
      if (in_rx_byte == start_code_r) begin
        collecting_nxt = 1'b1;
      end else if (in_rx_byte == end_code_r) begin
        collecting_nxt   = 1'b0;
        stored_count_nxt = '0;
        overflowed_nxt   = 1'b0;
        push             = 1'b1;
        push_entry.data  = (stored_count_r != '0) ? id_r : 8'd0;
        push_entry.cnt   = cnt_r[sohdf_pkg::CNT_FIELD_W-1:0];
        if (frame_bad) begin
          push_entry.op = sohdf_pkg::OP_BAD;
        end else if (cnt_r == 8'd0) begin
          push_entry.op = sohdf_pkg::OP_HEADER;
        end else begin
          push_entry.op = sohdf_pkg::OP_WORDS;
        end
      end else if (collecting_r) begin
        if (stored_count_r < CNT_W'(STORE_DEPTH)) begin
          stored_count_nxt = stored_count_r + CNT_W'(1);
          if (stored_count_r == CNT_W'(0)) begin
            id_nxt = in_rx_byte;
          end else if (stored_count_r == CNT_W'(1)) begin
            cnt_nxt = in_rx_byte;
          end else begin
            // Payload byte goes to its word row and byte lane.
            push            = 1'b1;
            push_entry.op   = sohdf_pkg::OP_STORE;
            push_entry.data = in_rx_byte;
            push_entry.row  = sohdf_pkg::ROW_FIELD_W'(pay_off >> 2);
            push_entry.lane = pay_off[1:0];
          end
        end else begin
          overflowed_nxt = 1'b1;
        end
      end
    end
  end

  // Frame tracking state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r   <= 1'b0;
      stored_count_r <= '0;
      overflowed_r   <= 1'b0;
    end else begin
      collecting_r   <= collecting_nxt;
      stored_count_r <= stored_count_nxt;
      overflowed_r   <= overflowed_nxt;
    end
  end

  // Header bytes need no reset; they are read only after being written.
  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

@@ rtl/sohdf_back.sv @@
// ----------------------------------------------------------------------------
// SOH/ETB deframer back end
// Executes queued operations: writes payload bytes into the word store and
// sequences result transactions out of a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "soh_etb_packet_deframer_unit_defines.svh"

module sohdf_back #(
  parameter int MAX_WORDS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sohdf_pkg::entry_t head,
  input  sohdf_pkg::qstat_t q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_packet_id,
  output logic [4:0]        out_word_count,
  output logic [3:0]        out_word_index,
  output logic [31:0]       out_data_word,
  output logic              out_has_data,
  output logic              out_bad_frame,
  output logic              out_last
);

  localparam int ROW_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW    = sohdf_pkg::CNT_FIELD_W;

  sohdf_pkg::bstate_t state_r, state_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      frame_cnt_r, frame_cnt_nxt;
  logic [7:0]         frame_id_r, frame_id_nxt;

  logic [3:0][7:0]    mem [MAX_WORDS];
  logic [3:0][7:0]    rd_word_r;
  logic               mem_we;
  logic               rd_en;

  logic               out_free;
  logic               load;
  logic [7:0]         ld_id;
  logic [CW-1:0]      ld_cnt;
  logic [CW-1:0]      ld_idx;
  logic [31:0]        ld_word;
  logic               ld_has_data;
  logic               ld_bad;
  logic               ld_last;
  logic               word_last;

  logic               out_valid_r;
  logic [7:0]         out_id_r;
  logic [4:0]         out_cnt_r;
  logic [3:0]         out_idx_r;
  logic [31:0]        out_word_r;
  logic               out_has_data_r;
  logic               out_bad_r;
  logic               out_last_r;

  assign out_free  = !out_valid_r || !out_stall;
  assign word_last = (idx_r == frame_cnt_r - CW'(1));

  // Sequencer: next state and datapath controls.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    frame_cnt_nxt = frame_cnt_r;
    frame_id_nxt  = frame_id_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    load          = 1'b0;
    ld_id         = frame_id_r;
    ld_cnt        = frame_cnt_r;
    ld_idx        = idx_r;
    ld_word       = rd_word_r;
    ld_has_data   = 1'b1;
    ld_bad        = 1'b0;
    ld_last       = word_last;
    unique case (state_r)
      sohdf_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          case (head.op) inside
            sohdf_pkg::OP_STORE: begin
              mem_we = 1'b1;
              pop    = 1'b1;
            end
            sohdf_pkg::OP_BAD, sohdf_pkg::OP_HEADER: begin
              if (out_free) begin
                load        = 1'b1;
                pop         = 1'b1;
                ld_id       = head.data;
                ld_cnt      = '0;
                ld_idx      = '0;
                ld_word     = '0;
                ld_has_data = 1'b0;
                ld_bad      = (head.op == sohdf_pkg::OP_BAD);
                ld_last     = 1'b1;
              end
            end
            sohdf_pkg::OP_WORDS: begin
              pop           = 1'b1;
              frame_id_nxt  = head.data;
              frame_cnt_nxt = head.cnt;
              idx_nxt       = '0;
              state_nxt     = sohdf_pkg::B_READ;
            end
            default: ;
          endcase
        end
      end
      sohdf_pkg::B_READ: begin
        rd_en     = 1'b1;
        state_nxt = sohdf_pkg::B_SEND;
      end
      sohdf_pkg::B_SEND: begin
        if (out_free) begin
          load    = 1'b1;
          idx_nxt = idx_r + CW'(1);
          state_nxt = word_last ? sohdf_pkg::B_IDLE : sohdf_pkg::B_READ;
        end
      end
      default: state_nxt = sohdf_pkg::B_IDLE;
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sohdf_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Frame context for word emission.
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    frame_cnt_r <= frame_cnt_nxt;
    frame_id_r  <= frame_id_nxt;
  end

  // Word store: byte-lane writes, whole-word registered reads.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[head.row[ROW_W-1:0]][head.lane] <= head.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word_r <= mem[idx_r[ROW_W-1:0]];
    end
  end

  // Output register: holds a result until the transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_id_r       <= ld_id;
      out_cnt_r      <= ld_cnt[4:0];
      out_idx_r      <= ld_idx[3:0];
      out_word_r     <= ld_word;
      out_has_data_r <= ld_has_data;
      out_bad_r      <= ld_bad;
      out_last_r     <= ld_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_packet_id  = out_id_r;
  assign out_word_count = out_cnt_r;
  assign out_word_index = out_idx_r;
  assign out_data_word  = out_word_r;
  assign out_has_data   = out_has_data_r;
  assign out_bad_frame  = out_bad_r;
  assign out_last       = out_last_r;

  // Checks.
  `SOHDF_CHK_NOW(a_pop_not_empty, pop, !q_stat.empty, "queue popped while empty")
  `SOHDF_CHK_NOW(a_idx_in_frame, state_r != sohdf_pkg::B_IDLE, idx_r < frame_cnt_r, "word index past frame")
  `SOHDF_CHK_NEXT(a_read_then_send, state_r == sohdf_pkg::B_READ, state_r == sohdf_pkg::B_SEND, "read not followed by send")
  `SOHDF_CHK_NOW(a_bad_shape, out_valid_r && out_bad_r, !out_has_data_r && out_last_r, "error result malformed")

endmodule

@@ rtl/soh_etb_packet_deframer_unit.sv @@
// An end code's error or header-only result goes via the operation queue to the output
// register; each data-frame word takes a read state (registered word-store read), then a
// send state that loads the output register once it is free. Bytes are taken one per cycle
// while the two-entry operation queue has room. Synchronous active-low reset clears control
// state and restores start code 1 and end code 23, but never clears the word store.
// ----------------------------------------------------------------------------
// SOH/ETB packet deframer
// Collects bytes between start and end codes, checks the frame layout and
// emits one result per payload word, a header-only result or an error result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module soh_etb_packet_deframer_unit #(
  parameter int MAX_WORDS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_packet_id,
  output logic [4:0]                      out_word_count,
  output logic [3:0]                      out_word_index,
  output logic [31:0]                     out_data_word,
  output logic                            out_has_data,
  output logic                            out_bad_frame,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sohdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data
);

  sohdf_pkg::qstat_t q_stat;
  sohdf_pkg::entry_t push_entry;
  sohdf_pkg::entry_t head;
  logic              push;
  logic              pop;

  // Byte classifier.
  sohdf_front #(
    .MAX_WORDS(MAX_WORDS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // Operation queue.
  sohdf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  // Store and result sequencer.
  sohdf_back #(
    .MAX_WORDS(MAX_WORDS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_packet_id  (out_packet_id),
    .out_word_count (out_word_count),
    .out_word_index (out_word_index),
    .out_data_word  (out_data_word),
    .out_has_data   (out_has_data),
    .out_bad_frame  (out_bad_frame),
    .out_last       (out_last)
  );

endmodule

@@ tb/sv/deframer_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SOH/ETB deframer checker
// Watches the byte, result and register channels of the deframer. It keeps
// its own copy of the codes and the frame store, works out the results that
// each accepted byte causes, and compares every accepted result, field by
// field, with the oldest expected one.
// ----------------------------------------------------------------------------

module deframer_checker #(
  parameter int MAX_WORDS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [7:0]                      in_rx_byte,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [7:0]                      out_packet_id,
  input  logic [4:0]                      out_word_count,
  input  logic [3:0]                      out_word_index,
  input  logic [31:0]                     out_data_word,
  input  logic                            out_has_data,
  input  logic                            out_bad_frame,
  input  logic                            out_last,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [sohdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data,
  output int                              errors,
  output int                              pending,
  output int                              results_seen
);

  localparam int STORE_DEPTH = 2 + 4 * MAX_WORDS;

  // One deframed result as the block should present it.
  typedef struct {
    logic [7:0]  id;
    logic [4:0]  count;
    logic [3:0]  index;
    logic [31:0] word;
    logic        has_data;
    logic        bad;
    logic        last;
  } deframed_t;

  deframed_t  deframed_q[$];
  logic [7:0] start_code_r;
  logic [7:0] end_code_r;
  bit         collecting;
  logic [7:0] frame_bytes[STORE_DEPTH];
  int         n_stored;
  bit         overflowed;
  int         n_err;
  int         n_seen;

  function automatic deframed_t make_result(logic [7:0] id, int count, int index,
                                            logic [31:0] word, bit has_data, bit bad,
                                            bit last);
    deframed_t r;
    r.id       = id;
    r.count    = count[4:0];
    r.index    = index[3:0];
    r.word     = word;
    r.has_data = has_data;
    r.bad      = bad;
    r.last     = last;
    return r;
  endfunction

  // An end code checks the stored frame and always empties the store.
  task automatic close_frame();
    logic [7:0]  id;
    logic [31:0] word;
    int          count;
    int          base;
    bit          bad;
    id    = (n_stored > 0) ? frame_bytes[0] : 8'h00;
    count = (n_stored >= 2) ? int'(frame_bytes[1]) : 0;
    bad   = overflowed || (n_stored < 2);
    if (!bad && count > MAX_WORDS) bad = 1'b1;
    if (!bad && (n_stored - 2) != count * 4) bad = 1'b1;
    if (bad) begin
      deframed_q.push_back(make_result(id, 0, 0, 32'h0, 1'b0, 1'b1, 1'b1));
    end else if (count == 0) begin
      deframed_q.push_back(make_result(id, 0, 0, 32'h0, 1'b0, 1'b0, 1'b1));
    end else begin
      for (int i = 0; i < count; i++) begin
        base = 2 + 4 * i;
        word = {frame_bytes[base + 3], frame_bytes[base + 2],
                frame_bytes[base + 1], frame_bytes[base]};
        deframed_q.push_back(make_result(id, count, i, word, 1'b1, 1'b0,
                                         (i + 1 == count)));
      end
    end
    n_stored   = 0;
    overflowed = 1'b0;
  endtask

  // The start code wins when both codes are equal.
  task automatic take_byte(input logic [7:0] b);
    if (b == start_code_r) begin
      collecting = 1'b1;
    end else if (b == end_code_r) begin
      collecting = 1'b0;
      close_frame();
    end else if (collecting) begin
      if (n_stored < STORE_DEPTH) begin
        frame_bytes[n_stored] = b;
        n_stored++;
      end else begin
        overflowed = 1'b1;
      end
    end
  endtask

  task automatic check_result();
    deframed_t e;
    bit        ok;
    n_seen++;
    if (deframed_q.size() == 0) begin
      n_err++;
      if (n_err <= 10)
        $display("%0t: unexpected result id=%h cnt=%0d idx=%0d word=%h data=%b bad=%b last=%b",
                 $realtime, out_packet_id, out_word_count, out_word_index, out_data_word,
                 out_has_data, out_bad_frame, out_last);
    end else begin
      e  = deframed_q.pop_front();
      ok = 1'b1;
      if (out_packet_id !== e.id) ok = 1'b0;
      if (out_word_count !== e.count) ok = 1'b0;
      if (out_word_index !== e.index) ok = 1'b0;
      if (out_data_word !== e.word) ok = 1'b0;
      if (out_has_data !== e.has_data) ok = 1'b0;
      if (out_bad_frame !== e.bad) ok = 1'b0;
      if (out_last !== e.last) ok = 1'b0;
      if (!ok) begin
        n_err++;
        if (n_err <= 10) begin
          $display("%0t: mismatch, expected id=%h cnt=%0d idx=%0d word=%h data=%b bad=%b last=%b",
                   $realtime, e.id, e.count, e.index, e.word, e.has_data, e.bad, e.last);
          $display("%0t:           actual id=%h cnt=%0d idx=%0d word=%h data=%b bad=%b last=%b",
                   $realtime, out_packet_id, out_word_count, out_word_index, out_data_word,
                   out_has_data, out_bad_frame, out_last);
        end
      end
    end
  endtask

  // Register writes, then the byte transaction, then the result transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      start_code_r = 8'd1;
      end_code_r   = 8'd23;
      collecting   = 1'b0;
      n_stored     = 0;
      overflowed   = 1'b0;
      n_err        = 0;
      n_seen       = 0;
      deframed_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sohdf_pkg::CFG_START_CODE) start_code_r = cfg_data;
        else if (cfg_index == sohdf_pkg::CFG_END_CODE) end_code_r = cfg_data;
      end
      if (in_valid && !in_stall) take_byte(in_rx_byte);
      if (out_valid && !out_stall) check_result();
    end
    errors       <= n_err;
    pending      <= deframed_q.size();
    results_seen <= n_seen;
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SOH/ETB packet deframer testbench
// Drives byte streams through the deframer under several start and end code
// settings: a directed set of edge cases, then random frames, most of them
// well formed, mixed with broken frames and noise. The checker beside the
// block predicts and compares the results; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int MAX_WORDS         = 16;
  localparam int STORE_DEPTH_BYTES = 2 + 4 * MAX_WORDS;
  localparam int HOLD_CYCLES       = 300;
  localparam int SETTLE            = 8;
  localparam int LIMIT             = 200000;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [7:0]                      in_rx_byte = 8'h00;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [7:0]                      out_packet_id;
  logic [4:0]                      out_word_count;
  logic [3:0]                      out_word_index;
  logic [31:0]                     out_data_word;
  logic                            out_has_data;
  logic                            out_bad_frame;
  logic                            out_last;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [sohdf_pkg::CFG_IDX_W-1:0] cfg_index = sohdf_pkg::CFG_START_CODE;
  logic [7:0]                      cfg_data = 8'h00;

  int         errors;
  int         pending;
  int         results_seen;
  int         n_bytes = 0;
  int         snd_idle = 0;
  int         rcv_idle = 0;
  bit         hold_go = 1'b0;
  bit         hold_used = 1'b0;
  int         hold_left = 0;
  int         cycles = 0;
  logic [7:0] cur_start = 8'd1;
  logic [7:0] cur_end = 8'd23;

  soh_etb_packet_deframer_unit #(
    .MAX_WORDS(MAX_WORDS)
  ) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_packet_id(out_packet_id), .out_word_count(out_word_count),
    .out_word_index(out_word_index), .out_data_word(out_data_word),
    .out_has_data(out_has_data), .out_bad_frame(out_bad_frame), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  deframer_checker #(
    .MAX_WORDS(MAX_WORDS)
  ) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_packet_id(out_packet_id), .out_word_count(out_word_count),
    .out_word_index(out_word_index), .out_data_word(out_data_word),
    .out_has_data(out_has_data), .out_bad_frame(out_bad_frame), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Safety net against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random stalls, or one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  // One byte transaction, with random idle cycles in front of it.
  task automatic put_byte(input logic [7:0] b);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_bytes++;
  endtask

  // Wait until every expected result has come and the block has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One register write; valid drops for a cycle before the next write.
  task automatic cfg_write(input logic [sohdf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_codes(input logic [7:0] s, input logic [7:0] e);
    cfg_write(sohdf_pkg::CFG_START_CODE, s);
    cfg_write(sohdf_pkg::CFG_END_CODE, e);
    cur_start = s;
    cur_end   = e;
  endtask

  // A byte that is neither code under the current setting.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == cur_start || b == cur_end) b = 8'($urandom_range(255));
    return b;
  endfunction

  function automatic int pick_count(input int lo, input int hi);
    int c;
    c = $urandom_range(hi, lo);
    while (c == cur_start || c == cur_end) c = $urandom_range(hi, lo);
    return c;
  endfunction

  // Start code, id, count byte, payload, end code; optionally a second start
  // code after the id, which must not disturb the frame.
  task automatic send_frame(input int count_byte, input int n_payload, input bit restart);
    put_byte(cur_start);
    put_byte(plain_byte());
    if (restart) put_byte(cur_start);
    put_byte(count_byte[7:0]);
    repeat (n_payload) put_byte(plain_byte());
    put_byte(cur_end);
  endtask

  task automatic random_frame();
    int kind;
    int w;
    int extra;
    kind = $urandom_range(99);
    if (kind < 68) begin
      extra = $urandom_range(99);
      if (extra < 75) w = pick_count(0, 3);
      else if (extra < 95) w = pick_count(4, 8);
      else w = pick_count(MAX_WORDS, MAX_WORDS);
      send_frame(w, 4 * w, 1'b0);
    end else if (kind < 76) begin
      // Payload length off from the declared count.
      w     = pick_count(0, 4);
      extra = $urandom_range(5, 1);
      if ($urandom_range(1) && 4 * w >= extra) extra = -extra;
      send_frame(w, 4 * w + extra, 1'b0);
    end else if (kind < 81) begin
      send_frame(pick_count(MAX_WORDS + 1, 255), $urandom_range(8), 1'b0);
    end else if (kind < 86) begin
      // Too short to hold a header.
      put_byte(cur_start);
      if ($urandom_range(1)) put_byte(plain_byte());
      put_byte(cur_end);
    end else if (kind < 89) begin
      put_byte(cur_end);
    end else if (kind < 93) begin
      w = pick_count(0, 3);
      send_frame(w, 4 * w, 1'b1);
    end else if (kind < 98) begin
      repeat ($urandom_range(6, 1)) put_byte(8'($urandom_range(255)));
    end else begin
      put_byte(cur_start);
      repeat (STORE_DEPTH_BYTES + $urandom_range(6, 1)) put_byte(plain_byte());
      put_byte(cur_end);
    end
  endtask

  task automatic run_phase(input int budget);
    int first;
    first = n_bytes;
    while (n_bytes - first < budget) random_frame();
    settle();
  endtask

  task automatic set_idle(input int snd_pct, input int rcv_pct);
    snd_idle = snd_pct;
    rcv_idle <= rcv_pct;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender mostly busy, receiver mostly stalling.
    set_idle(18, 78);
    set_codes(8'd1, 8'd23);

    // Directed edge cases under the default codes.
    put_byte(cur_end);                                 // end code with empty store
    put_byte(cur_start); put_byte(8'h00); put_byte(8'h00);
    put_byte(cur_end);                                 // header only, id zero
    put_byte(cur_start); put_byte(8'hFF); put_byte(8'h02);
    repeat (4) put_byte(8'h00);
    repeat (4) put_byte(8'hFF);
    put_byte(cur_end);                                 // two words at the extremes
    put_byte(cur_start); put_byte(8'hAA); put_byte(cur_end);      // one byte only
    put_byte(cur_start); put_byte(8'h05); put_byte(8'h11); put_byte(cur_end);
    put_byte(cur_start); put_byte(8'h07); put_byte(8'h00); put_byte(8'h55);
    put_byte(cur_end);                                 // length mismatch
    settle();

    // Equal codes: the shared byte only starts collection. The frame is
    // closed after the end code is moved elsewhere.
    set_codes(8'h7E, 8'h7E);
    put_byte(8'h7E); put_byte(8'h42); put_byte(8'h7E); put_byte(8'h00); put_byte(8'h7E);
    settle();
    set_codes(8'h7E, 8'h23);
    put_byte(8'h23);
    settle();

    // Lowest start code, highest end code, with one overflowing frame.
    set_codes(8'h00, 8'hFF);
    put_byte(cur_start);
    repeat (STORE_DEPTH_BYTES + 4) put_byte(plain_byte());
    put_byte(cur_end);
    run_phase(35);

    // Sender mostly idle, receiver mostly ready.
    set_idle(78, 18);
    set_codes(8'hFF, 8'h00);
    run_phase(35);
    set_codes(8'($urandom_range(255, 32)), 8'h00);
    cfg_write(sohdf_pkg::CFG_END_CODE, 8'($urandom_range(255, 32)));
    while (cfg_data == cur_start) cfg_write(sohdf_pkg::CFG_END_CODE,
                                            8'($urandom_range(255, 32)));
    cur_end = cfg_data;
    run_phase(30);

    // No idling, and a long hold-off on the result side so the block backs up.
    set_idle(0, 0);
    set_codes(8'd1, 8'd23);
    hold_go <= 1'b1;
    send_frame(MAX_WORDS, 4 * MAX_WORDS, 1'b0);
    repeat (3) random_frame();
    run_phase(20);

    settle();
    repeat (20) @(posedge clk);
    $display("Run covered %0d bytes under several code settings; %0d results were checked.",
             n_bytes, results_seen);
    $display("Directed edge cases, overflow, equal codes, idle mixes and a long hold-off.");
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
